// File: hw/rtl/mrrm_pkg.sv
// Shared constants, codes and word types of the receive ring manager.
`timescale 1ns / 1ps

package mrrm_pkg;

   localparam int CHANNELS   = 8;
   localparam int RING_DEPTH = 1024;
   localparam int LINE_MAX   = 16;

   localparam int CHAN_W  = $clog2(CHANNELS);
   localparam int PTR_W   = $clog2(RING_DEPTH);
   localparam int RING_AW = $clog2(CHANNELS * RING_DEPTH);
   localparam int LEN_W   = $clog2(LINE_MAX);

   localparam logic [CHAN_W-1:0] TOP_CHAN = CHAN_W'(CHANNELS - 1);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_G  = 8'h47;
   localparam logic [7:0] CHAR_R  = 8'h52;
   localparam logic [7:0] CHAR_A  = 8'h41;
   localparam logic [7:0] CHAR_B  = 8'h42;

   localparam logic [2:0] FN_RECV   = 3'd0;
   localparam logic [2:0] FN_READ   = 3'd1;
   localparam logic [2:0] FN_OPEN   = 3'd2;
   localparam logic [2:0] FN_CLOSE  = 3'd3;
   localparam logic [2:0] FN_RCLOSE = 3'd4;

   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_FULL    = 3'd1;
   localparam logic [2:0] STS_EMPTY   = 3'd2;
   localparam logic [2:0] STS_NO_CHAN = 3'd3;
   localparam logic [2:0] STS_NOT_OPEN = 3'd4;

   typedef struct packed {
      logic [2:0] func;
      logic [2:0] chan;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] data_out;
      logic [2:0] chan_out;
      logic       send_open;
      logic       send_close;
      logic       grab_request;
   } rsp_type;

   typedef struct packed {
      logic [PTR_W-1:0] rp;
      logic [PTR_W-1:0] wp;
   } ptr_pair_type;

   typedef struct packed {
      logic              rd_en;
      logic [CHAN_W-1:0] rd_addr;
      logic              wr_en;
      logic [CHAN_W-1:0] wr_addr;
      ptr_pair_type      wr_data;
      logic              clr_en;
      logic [CHAN_W-1:0] clr_addr;
   } ptr_ctl_type;

   typedef struct packed {
      logic               rd_en;
      logic [RING_AW-1:0] rd_addr;
      logic               wr_en;
      logic [RING_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
   } ring_ctl_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + (PTR_W+1)'(1);
      return (sum >= (PTR_W+1)'(RING_DEPTH)) ? '0 : sum[PTR_W-1:0];
   endfunction

   function automatic logic [RING_AW-1:0] ring_addr(input logic [CHAN_W-1:0] ch,
                                                    input logic [PTR_W-1:0]  p);
      return RING_AW'(ch) * RING_AW'(RING_DEPTH) + RING_AW'(p);
   endfunction

endpackage

// File: hw/rtl/mrrm_ring_ram.sv
// Byte store holding every channel's ring, one read and one write port.
`timescale 1ns / 1ps

module mrrm_ring_ram
   import mrrm_pkg::*;
(
   input  logic         clock,
   input  ring_ctl_type ctl,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [CHANNELS * RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mrrm_ptr_table.sv
// Per-channel read/write pointer memory; entries read as zero until written.
`timescale 1ns / 1ps

module mrrm_ptr_table
   import mrrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ptr_ctl_type  ctl,
   output ptr_pair_type rd_data
);

   ptr_pair_type          mem [CHANNELS];
   logic [CHANNELS-1:0]   valid_ff;
   ptr_pair_type          rd_raw_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff <= mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_addr] <= 1'b1;
         end
         // clearing a channel's pointers just drops its valid bit
         if (ctl.clr_en) begin
            valid_ff[ctl.clr_addr] <= 1'b0;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

// File: hw/rtl/mrrm_line_acc.sv
// Line accumulator for the top channel: flags lines that start with GRAB.
`timescale 1ns / 1ps

module mrrm_line_acc
   import mrrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       feed_en,
   input  logic [7:0] feed_byte,
   output logic       grab
);

   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       prefix_ff [4];
   logic [7:0]       prefix_in [4];
   logic             eol;

   assign eol = (feed_byte == CHAR_CR) || (feed_byte == CHAR_LF);

   always_comb begin
      len_in    = len_ff;
      prefix_in = prefix_ff;
      grab      = 1'b0;
      if (feed_en) begin
         if (eol) begin
            grab = (len_ff >= LEN_W'(4)) && (prefix_ff[0] == CHAR_G) &&
                   (prefix_ff[1] == CHAR_R) && (prefix_ff[2] == CHAR_A) &&
                   (prefix_ff[3] == CHAR_B);
            len_in = '0;
         end else if (len_ff < LEN_W'(LINE_MAX - 1)) begin
            if (len_ff < LEN_W'(4)) begin
               prefix_in[len_ff[1:0]] = feed_byte;
            end
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            prefix_ff[i] <= '0;
         end
      end else begin
         len_ff    <= len_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// File: hw/rtl/multichannel_receive_ring_manager.sv
// Top level: command sequencer, channel in-use marks and result register.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. Its result word shows
// on rsp_data for one cycle with rsp_valid high, and must be taken then. Receive,
// open and close commands, and a read of an empty ring, go from S_EXEC back to
// idle; a read that pops a byte passes through S_FETCH as well, since the byte
// comes from the synchronous ring memory in the cycle after the pointer memory
// read. The pointer memory is read on accept and written back in the following
// cycle, before the next command can be taken.
// Bytes received on the top channel go to the GRAB line detector, not a ring.
module multichannel_receive_ring_manager
   import mrrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_FETCH = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                link_up_ff;
   logic [CHANNELS-1:0] in_use_ff, in_use_in;

   ptr_ctl_type         ptr_ctl;
   ptr_pair_type        ptr_rd;
   ring_ctl_type        ring_ctl;
   logic [7:0]          ring_rd;

   logic                accept;
   logic                chan_ok;
   logic [CHAN_W-1:0]   ch;
   logic                free_found;
   logic [CHAN_W-1:0]   free_idx;
   logic                feed_en;
   logic                grab;
   logic [PTR_W-1:0]    wp_next;
   logic [PTR_W-1:0]    rp_next;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign chan_ok = 32'(req_ff.chan) < 32'(CHANNELS);
   assign ch      = CHAN_W'(req_ff.chan);
   assign wp_next = ring_next(ptr_rd.wp);
   assign rp_next = ring_next(ptr_rd.rp);
   assign feed_en = (state_ff == S_EXEC) && (req_ff.func == FN_RECV) && chan_ok &&
                    (ch == TOP_CHAN);

   // lowest free channel
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = CHANNELS - 1; k >= 0; k--) begin
         if (!in_use_ff[k]) begin
            free_found = 1'b1;
            free_idx   = CHAN_W'(k);
         end
      end
   end

   mrrm_ptr_table u_ptr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ptr_ctl),
      .rd_data (ptr_rd)
   );

   mrrm_ring_ram u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .rd_data (ring_rd)
   );

   mrrm_line_acc u_line (
      .clock     (clock),
      .reset     (reset),
      .feed_en   (feed_en),
      .feed_byte (req_ff.data_in),
      .grab      (grab)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      in_use_in    = in_use_ff;
      ptr_ctl      = '0;
      ring_ctl     = '0;

      ptr_ctl.rd_addr = CHAN_W'(req_data.chan);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ptr_ctl.rd_en = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (req_ff.func)
               FN_RECV: begin
                  if (!chan_ok) begin
                     rsp_in.status = STS_NOT_OPEN;
                  end else if (ch == TOP_CHAN) begin
                     rsp_in.grab_request = grab;
                  end else if (wp_next == ptr_rd.rp) begin
                     rsp_in.status = STS_FULL;
                  end else begin
                     ring_ctl.wr_en   = 1'b1;
                     ring_ctl.wr_addr = ring_addr(ch, ptr_rd.wp);
                     ring_ctl.wr_data = req_ff.data_in;
                     ptr_ctl.wr_en    = 1'b1;
                     ptr_ctl.wr_addr  = ch;
                     ptr_ctl.wr_data  = '{rp: ptr_rd.rp, wp: wp_next};
                  end
               end
               FN_READ: begin
                  if (!chan_ok) begin
                     rsp_in.status = STS_NOT_OPEN;
                  end else if (ptr_rd.rp == ptr_rd.wp) begin
                     rsp_in.status = STS_EMPTY;
                  end else begin
                     ring_ctl.rd_en   = 1'b1;
                     ring_ctl.rd_addr = ring_addr(ch, ptr_rd.rp);
                     ptr_ctl.wr_en    = 1'b1;
                     ptr_ctl.wr_addr  = ch;
                     ptr_ctl.wr_data  = '{rp: rp_next, wp: ptr_rd.wp};
                     rsp_valid_in     = 1'b0;
                     state_in         = S_FETCH;
                  end
               end
               FN_OPEN: begin
                  if (link_up_ff && free_found) begin
                     in_use_in[free_idx] = 1'b1;
                     ptr_ctl.clr_en      = 1'b1;
                     ptr_ctl.clr_addr    = free_idx;
                     rsp_in.chan_out     = 3'(free_idx);
                     rsp_in.send_open    = 1'b1;
                  end else begin
                     rsp_in.status = STS_NO_CHAN;
                  end
               end
               FN_CLOSE: begin
                  if (!chan_ok || !in_use_ff[ch]) begin
                     rsp_in.status = STS_NOT_OPEN;
                  end else begin
                     in_use_in[ch]     = 1'b0;
                     rsp_in.send_close = 1'b1;
                  end
               end
               FN_RCLOSE: begin
                  if (!chan_ok) begin
                     rsp_in.status = STS_NOT_OPEN;
                  end else begin
                     in_use_in[ch] = 1'b0;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         S_FETCH: begin
            rsp_in          = '0;
            rsp_in.data_out = ring_rd;
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         link_up_ff   <= 1'b0;
         // only the top channel starts reserved
         in_use_ff    <= {1'b1, (CHANNELS-1)'(0)};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         in_use_ff    <= in_use_in;
         if (csr_we) begin
            link_up_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result word only follows work in flight
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC) || $past(state_ff == S_FETCH))
      else $error("result word without a command in flight");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted command did not start execution");

   a_open_needs_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_open |-> rsp_ff.status == STS_OK && link_up_ff)
      else $error("channel opened while link down");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.data_out != 8'd0) |-> rsp_ff.status == STS_OK)
      else $error("data returned with error status");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !$past(rsp_valid_ff))
      else $error("two result words back to back from one command");

endmodule
